// ----- design/afk_pkg.sv -----
// package for the arm forward kinematics block: widths, fixed-point constants,
// the cordic arctangent table and the structs passed between the modules
// no dependencies
package afk_pkg;

  localparam int CordicSteps = 16;     // 12 .. 24
  localparam int AtanIdxW    = 5;      // index into the 24-entry arctangent table

  localparam int AngW  = 36;           // q30 angle before range reduction
  localparam int ZW    = 34;           // q30 residual angle in the cordic cells
  localparam int XyW   = 33;           // q30 cordic vector
  localparam int TrigW = 34;           // q30 sin/cos after the fold sign is applied
  localparam int ProdW = 48;           // trig times link offset
  localparam int SumW  = 50;           // exact q30 coordinate sums
  localparam int PosW  = 17;           // rounded position

  localparam logic signed [AngW-1:0] AngPi     = 36'sd3373259426;
  localparam logic signed [AngW-1:0] AngTwoPi  = 36'sd6746518852;
  localparam logic signed [AngW-1:0] AngHalfPi = 36'sd1686629713;
  localparam logic signed [XyW-1:0]  CordicGain = 33'sd652032874;

  localparam logic signed [ProdW-1:0] OfsLiftZ     = 48'sd5571;
  localparam logic signed [ProdW-1:0] OfsShoulderX = 48'sd2310;
  localparam logic signed [ProdW-1:0] OfsUpperX    = 48'sd82;
  localparam logic signed [ProdW-1:0] OfsUpperZ    = 48'sd5652;
  localparam logic signed [ProdW-1:0] OfsPalmX     = 48'sd197;
  localparam logic signed [ProdW-1:0] OfsPalmZ     = 48'sd2302;
  localparam logic signed [ProdW-1:0] OfsCamXMag   = 48'sd442;  // camera x offset is negative
  localparam logic signed [ProdW-1:0] OfsCamZ      = 48'sd2228;

  localparam int Q30Shift = 30;
  localparam logic signed [SumW-1:0] Q30Half = 50'sd536870912;

  // configuration register indexes
  localparam logic [2:0] RegLiftMin  = 3'd0;
  localparam logic [2:0] RegLiftMax  = 3'd1;
  localparam logic [2:0] RegArmMin   = 3'd2;
  localparam logic [2:0] RegArmMax   = 3'd3;
  localparam logic [2:0] RegWristMin = 3'd4;
  localparam logic [2:0] RegWristMax = 3'd5;

  typedef struct packed {
    logic signed [15:0] lift_min;
    logic signed [15:0] lift_max;
    logic signed [15:0] arm_min;
    logic signed [15:0] arm_max;
    logic signed [15:0] wrist_min;
    logic signed [15:0] wrist_max;
  } afk_cfg_t;

  // data handed from cell to cell: arm and hand rotations side by side
  typedef struct packed {
    logic signed [15:0]    lift;
    logic signed [15:0]    hp;
    logic                  neg_a;
    logic                  neg_h;
    logic signed [XyW-1:0] xa;
    logic signed [XyW-1:0] ya;
    logic signed [ZW-1:0]  za;
    logic signed [XyW-1:0] xh;
    logic signed [XyW-1:0] yh;
    logic signed [ZW-1:0]  zh;
  } afk_cord_t;

  // atan(2^-i) in q30, truncated
  function automatic logic signed [ZW-1:0] atan_q30(logic [AtanIdxW-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 34'sd843314856;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043836;
      5'd3:  r = 34'sd133525158;
      5'd4:  r = 34'sd67021686;
      5'd5:  r = 34'sd33543515;
      5'd6:  r = 34'sd16775850;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194282;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/afk_front.sv -----
// front end of the kinematics pipeline: input register, limit clamps,
// hand pitch saturation and reduction of both angles into [-pi/2, pi/2]
// depends on afk_pkg
module afk_front import afk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               in_valid_i,
  input  logic signed [15:0] lift_height_i,
  input  logic signed [15:0] arm_angle_i,
  input  logic signed [15:0] wrist_angle_i,
  input  afk_cfg_t           cfg_i,
  output logic               vld_o,
  output afk_cord_t          cord_o
);

  logic [4:0] vld_q, vld_d;

  // stage 1: raw item
  logic signed [15:0] lift1_q, af1_q, wf1_q;
  // stage 2: clamped
  logic signed [15:0] lift2_q, af2_q, wf2_q, lift2_d, af2_d, wf2_d;
  // stage 3: q30 angles and hand pitch
  logic signed [15:0]     lift3_q, hp3_q, hp3_d;
  logic signed [AngW-1:0] za3_q, zh3_q, za3_d, zh3_d;
  logic signed [16:0]     arm_ang;
  logic signed [17:0]     hp_sum;
  // stage 4: wrapped into [-pi, pi]
  logic signed [15:0]     lift4_q, hp4_q;
  logic signed [AngW-1:0] za4_q, zh4_q, za4_d, zh4_d;
  // stage 5: folded
  afk_cord_t cord5_q, cord5_d;

  function automatic logic signed [15:0] clamp16(logic signed [15:0] v,
                                                 logic signed [15:0] lo,
                                                 logic signed [15:0] hi);
    logic signed [15:0] r;
    r = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  function automatic logic signed [AngW-1:0] wrap(logic signed [AngW-1:0] z);
    logic signed [AngW-1:0] r;
    r = z;
    if (z > AngPi) begin
      r = z - AngTwoPi;
    end else if (z < -AngPi) begin
      r = z + AngTwoPi;
    end
    return r;
  endfunction

  always_comb begin
    vld_d = {vld_q[3:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    lift2_d = clamp16(lift1_q, cfg_i.lift_min, cfg_i.lift_max);
    af2_d   = clamp16(af1_q, cfg_i.arm_min, cfg_i.arm_max);
    wf2_d   = clamp16(wf1_q, cfg_i.wrist_min, cfg_i.wrist_max);
  end

  always_comb begin
    arm_ang = -17'(af2_q);
    hp_sum  = -18'(af2_q) - 18'(wf2_q);
    if (hp_sum > 18'sd32767) begin
      hp3_d = 16'sh7fff;
    end else if (hp_sum < -18'sd32768) begin
      hp3_d = 16'sh8000;
    end else begin
      hp3_d = 16'(hp_sum);
    end
    za3_d = AngW'(arm_ang) <<< 18;
    zh3_d = AngW'(hp3_d) <<< 18;
  end

  always_comb begin
    za4_d = wrap(za3_q);
    zh4_d = wrap(zh3_q);
  end

  // fold by pi; the sign flip is applied after the rotation
  always_comb begin
    cord5_d.lift  = lift4_q;
    cord5_d.hp    = hp4_q;
    cord5_d.xa    = CordicGain;
    cord5_d.ya    = '0;
    cord5_d.xh    = CordicGain;
    cord5_d.yh    = '0;
    cord5_d.neg_a = 1'b0;
    cord5_d.neg_h = 1'b0;
    cord5_d.za    = ZW'(za4_q);
    cord5_d.zh    = ZW'(zh4_q);
    if (za4_q > AngHalfPi) begin
      cord5_d.za    = ZW'(za4_q - AngPi);
      cord5_d.neg_a = 1'b1;
    end else if (za4_q < -AngHalfPi) begin
      cord5_d.za    = ZW'(za4_q + AngPi);
      cord5_d.neg_a = 1'b1;
    end
    if (zh4_q > AngHalfPi) begin
      cord5_d.zh    = ZW'(zh4_q - AngPi);
      cord5_d.neg_h = 1'b1;
    end else if (zh4_q < -AngHalfPi) begin
      cord5_d.zh    = ZW'(zh4_q + AngPi);
      cord5_d.neg_h = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lift1_q <= lift_height_i;
      af1_q   <= arm_angle_i;
      wf1_q   <= wrist_angle_i;
      lift2_q <= lift2_d;
      af2_q   <= af2_d;
      wf2_q   <= wf2_d;
      lift3_q <= lift2_q;
      hp3_q   <= hp3_d;
      za3_q   <= za3_d;
      zh3_q   <= zh3_d;
      lift4_q <= lift3_q;
      hp4_q   <= hp3_q;
      za4_q   <= za4_d;
      zh4_q   <= zh4_d;
      cord5_q <= cord5_d;
    end
  end

  assign vld_o  = vld_q[4];
  assign cord_o = cord5_q;

endmodule

// ----- design/afk_cell.sv -----
// one cordic rotation step for the arm and the hand angle, registered
// depends on afk_pkg
module afk_cell import afk_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic [AtanIdxW-1:0] step_i,
  input  logic                vld_i,
  input  afk_cord_t           cord_i,
  output logic                vld_o,
  output afk_cord_t           cord_o
);

  logic                 vld_q;
  afk_cord_t            cord_q, cord_d;
  logic signed [ZW-1:0] ang;

  always_comb begin
    ang    = atan_q30(step_i);
    cord_d = cord_i;
    if (!cord_i.za[ZW-1]) begin
      cord_d.xa = cord_i.xa - (cord_i.ya >>> step_i);
      cord_d.ya = cord_i.ya + (cord_i.xa >>> step_i);
      cord_d.za = cord_i.za - ang;
    end else begin
      cord_d.xa = cord_i.xa + (cord_i.ya >>> step_i);
      cord_d.ya = cord_i.ya - (cord_i.xa >>> step_i);
      cord_d.za = cord_i.za + ang;
    end
    if (!cord_i.zh[ZW-1]) begin
      cord_d.xh = cord_i.xh - (cord_i.yh >>> step_i);
      cord_d.yh = cord_i.yh + (cord_i.xh >>> step_i);
      cord_d.zh = cord_i.zh - ang;
    end else begin
      cord_d.xh = cord_i.xh + (cord_i.yh >>> step_i);
      cord_d.yh = cord_i.yh - (cord_i.xh >>> step_i);
      cord_d.zh = cord_i.zh + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cord_q <= cord_d;
    end
  end

  assign vld_o  = vld_q;
  assign cord_o = cord_q;

endmodule

// ----- design/afk_back.sv -----
// back end: fold sign, link offset products, exact q30 sums, rounding and
// the output register
// depends on afk_pkg
module afk_back import afk_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    vld_i,
  input  afk_cord_t               cord_i,
  output logic                    out_valid_o,
  output logic signed [PosW-1:0]  palm_x_o,
  output logic signed [PosW-1:0]  palm_z_o,
  output logic signed [PosW-1:0]  camera_x_o,
  output logic signed [PosW-1:0]  camera_z_o,
  output logic signed [15:0]      hand_pitch_o
);

  logic [3:0] vld_q;

  // b0: signed sin/cos
  logic signed [TrigW-1:0] ca_q, sa_q, ch_q, sh_q;
  logic signed [15:0]      lift0_q, hp0_q;
  // b1: products
  logic signed [ProdW-1:0] p_q [12];
  logic signed [ProdW-1:0] p_d [12];
  logic signed [15:0]      lift1_q, hp1_q;
  // b2: wrist point and hand offsets
  logic signed [SumW-1:0]  wx_q, wz_q, pdx_q, pdz_q, cdx_q, cdz_q;
  logic signed [SumW-1:0]  wx_d, wz_d, pdx_d, pdz_d, cdx_d, cdz_d;
  logic signed [15:0]      hp2_q;
  // b3: output register
  logic signed [SumW-1:0]  px_s, pz_s, cx_s, cz_s;
  logic signed [PosW-1:0]  px_q, pz_q, cx_q, cz_q;
  logic signed [15:0]      hp3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_comb begin
    p_d[0]  = ProdW'(ca_q) * OfsUpperX;
    p_d[1]  = ProdW'(ca_q) * OfsUpperZ;
    p_d[2]  = ProdW'(sa_q) * OfsUpperX;
    p_d[3]  = ProdW'(sa_q) * OfsUpperZ;
    p_d[4]  = ProdW'(ch_q) * OfsPalmX;
    p_d[5]  = ProdW'(ch_q) * OfsPalmZ;
    p_d[6]  = ProdW'(sh_q) * OfsPalmX;
    p_d[7]  = ProdW'(sh_q) * OfsPalmZ;
    p_d[8]  = ProdW'(ch_q) * OfsCamXMag;
    p_d[9]  = ProdW'(ch_q) * OfsCamZ;
    p_d[10] = ProdW'(sh_q) * OfsCamXMag;
    p_d[11] = ProdW'(sh_q) * OfsCamZ;
  end

  always_comb begin
    wx_d  = (SumW'(OfsShoulderX) <<< Q30Shift) + SumW'(p_q[0]) + SumW'(p_q[3]);
    wz_d  = ((SumW'(OfsLiftZ) + SumW'(lift1_q)) <<< Q30Shift)
            - SumW'(p_q[2]) + SumW'(p_q[1]);
    pdx_d = SumW'(p_q[4]) + SumW'(p_q[7]);
    pdz_d = SumW'(p_q[5]) - SumW'(p_q[6]);
    // camera x offset is negative: its terms change sign
    cdx_d = SumW'(p_q[11]) - SumW'(p_q[8]);
    cdz_d = SumW'(p_q[9]) + SumW'(p_q[10]);
  end

  always_comb begin
    px_s = wx_q + pdx_q + Q30Half;
    pz_s = wz_q + pdz_q + Q30Half;
    cx_s = wx_q + cdx_q + Q30Half;
    cz_s = wz_q + cdz_q + Q30Half;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ca_q    <= cord_i.neg_a ? -TrigW'(cord_i.xa) : TrigW'(cord_i.xa);
      sa_q    <= cord_i.neg_a ? -TrigW'(cord_i.ya) : TrigW'(cord_i.ya);
      ch_q    <= cord_i.neg_h ? -TrigW'(cord_i.xh) : TrigW'(cord_i.xh);
      sh_q    <= cord_i.neg_h ? -TrigW'(cord_i.yh) : TrigW'(cord_i.yh);
      lift0_q <= cord_i.lift;
      hp0_q   <= cord_i.hp;
      p_q     <= p_d;
      lift1_q <= lift0_q;
      hp1_q   <= hp0_q;
      wx_q    <= wx_d;
      wz_q    <= wz_d;
      pdx_q   <= pdx_d;
      pdz_q   <= pdz_d;
      cdx_q   <= cdx_d;
      cdz_q   <= cdz_d;
      hp2_q   <= hp1_q;
      px_q    <= px_s[Q30Shift+PosW-1:Q30Shift];
      pz_q    <= pz_s[Q30Shift+PosW-1:Q30Shift];
      cx_q    <= cx_s[Q30Shift+PosW-1:Q30Shift];
      cz_q    <= cz_s[Q30Shift+PosW-1:Q30Shift];
      hp3_q   <= hp2_q;
    end
  end

  assign out_valid_o  = vld_q[3];
  assign palm_x_o     = px_q;
  assign palm_z_o     = pz_q;
  assign camera_x_o   = cx_q;
  assign camera_z_o   = cz_q;
  assign hand_pitch_o = hp3_q;

endmodule

// ----- design/arm_forward_kinematics.sv -----
// top level of the arm forward kinematics pipeline: configuration registers,
// front end, a chain of cordic cells and the back end
// depends on afk_pkg, afk_front, afk_cell, afk_back
//
//   port group  direction  handshake                  payload
//   in          input      in_valid_i / in_stall_o    lift_height_i, arm_angle_i,
//                                                     wrist_angle_i
//   out         output     out_valid_o / out_stall_i  palm_x_o, palm_z_o, camera_x_o,
//                                                     camera_z_o, hand_pitch_o
//   cfg         input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// one pose enters per cycle while the pipeline advances; its depth is set by the
// length of the cordic cell chain plus the clamp, angle reduction,
// multiply and sum stages
// the whole pipeline moves as one: it advances whenever the output register is
// empty or its result is taken, so a stalled output holds every stage
// reset clears the valid bits and loads the default limits; no clearing pass
module arm_forward_kinematics import afk_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [15:0]     lift_height_i,
  input  logic signed [15:0]     arm_angle_i,
  input  logic signed [15:0]     wrist_angle_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [PosW-1:0] palm_x_o,
  output logic signed [PosW-1:0] palm_z_o,
  output logic signed [PosW-1:0] camera_x_o,
  output logic signed [PosW-1:0] camera_z_o,
  output logic signed [15:0]     hand_pitch_o,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [15:0]            cfg_data_i
);

  afk_cfg_t  cfg_q, cfg_d;
  logic      adv;
  logic      chain_vld  [CordicSteps+1];
  afk_cord_t chain_cord [CordicSteps+1];

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLiftMin:  cfg_d.lift_min  = cfg_data_i;
        RegLiftMax:  cfg_d.lift_max  = cfg_data_i;
        RegArmMin:   cfg_d.arm_min   = cfg_data_i;
        RegArmMax:   cfg_d.arm_max   = cfg_data_i;
        RegWristMin: cfg_d.wrist_min = cfg_data_i;
        RegWristMax: cfg_d.wrist_max = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lift_min  <= 16'sd0;
      cfg_q.lift_max  <= 16'sd11305;
      cfg_q.arm_min   <= -16'sd10732;
      cfg_q.arm_max   <= 16'sd0;
      cfg_q.wrist_min <= -16'sd7864;
      cfg_q.wrist_max <= 16'sd4997;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  afk_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .in_valid_i    (in_valid_i),
    .lift_height_i (lift_height_i),
    .arm_angle_i   (arm_angle_i),
    .wrist_angle_i (wrist_angle_i),
    .cfg_i         (cfg_q),
    .vld_o         (chain_vld[0]),
    .cord_o        (chain_cord[0])
  );

  for (genvar k = 0; k < CordicSteps; k++) begin : g_cell
    afk_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .step_i (AtanIdxW'(k)),
      .vld_i  (chain_vld[k]),
      .cord_i (chain_cord[k]),
      .vld_o  (chain_vld[k+1]),
      .cord_o (chain_cord[k+1])
    );
  end

  afk_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .vld_i        (chain_vld[CordicSteps]),
    .cord_i       (chain_cord[CordicSteps]),
    .out_valid_o  (out_valid_o),
    .palm_x_o     (palm_x_o),
    .palm_z_o     (palm_z_o),
    .camera_x_o   (camera_x_o),
    .camera_z_o   (camera_z_o),
    .hand_pitch_o (hand_pitch_o)
  );

endmodule

// ----- test/tb_arm_forward_kinematics.sv -----
// testbench for arm_forward_kinematics: directed and random poses through the valid/stall
// handshake, each result checked field by field against a bit-exact kinematics predictor
// depends on afk_pkg and the design files
module tb_arm_forward_kinematics import afk_pkg::*; ();

  localparam int CycleLimit = 200000;

  // q30 angle and gain constants of the sine/cosine unit
  localparam longint HalfTurn    = 64'sd3373259426;
  localparam longint FullTurn    = 64'sd6746518852;
  localparam longint QuarterTurn = 64'sd1686629713;
  localparam longint StartGain   = 64'sd652032874;
  localparam longint Q30One      = 64'sd1073741824;
  localparam longint RoundHalf   = 64'sd536870912;

  // link offsets, 1/16384 m
  localparam longint LiftBaseZ = 5571;
  localparam longint ShoulderX = 2310;
  localparam longint UpperX    = 82;
  localparam longint UpperZ    = 5652;
  localparam longint PalmX     = 197;
  localparam longint PalmZ     = 2302;
  localparam longint CamX      = -442;
  localparam longint CamZ      = 2228;

  // indexes with no register behind them
  localparam logic [2:0] RegSpare6 = 3'd6;
  localparam logic [2:0] RegSpare7 = 3'd7;

  typedef enum int {LimDefault, LimFull, LimRandom, LimInverted, LimPinned} limit_mode_e;
  typedef enum int {RxFree, RxLight, RxHeavy, RxToggle} stall_pattern_e;

  typedef struct packed {
    logic signed [PosW-1:0] palm_x;
    logic signed [PosW-1:0] palm_z;
    logic signed [PosW-1:0] camera_x;
    logic signed [PosW-1:0] camera_z;
    logic signed [15:0]     hand_pitch;
  } pose_t;

  class pose_scoreboard;
    int lift_min, lift_max, arm_min, arm_max, wrist_min, wrist_max;
    int errors;
    longint atan_tab[24];
    pose_t pending_poses[$];

    function new();
      lift_min  = 0;
      lift_max  = 11305;
      arm_min   = -10732;
      arm_max   = 0;
      wrist_min = -7864;
      wrist_max = 4997;
      errors    = 0;
      atan_tab  = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                    262143, 131071, 65535, 32767, 16383, 8191,
                    4095, 2047, 1023, 511, 255, 127};
    endfunction

    function void set_limit(logic [2:0] idx, logic [15:0] data);
      int v;
      v = int'($signed(data));
      case (idx)
        RegLiftMin:  lift_min = v;
        RegLiftMax:  lift_max = v;
        RegArmMin:   arm_min = v;
        RegArmMax:   arm_max = v;
        RegWristMin: wrist_min = v;
        RegWristMax: wrist_max = v;
        default: ;
      endcase
    endfunction

    // lower bound first, so inverted limits end at the upper bound
    function int limit_to(int v, int lo, int hi);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
    endfunction

    // ang in 1/4096 rad, cos and sin in q30
    function void unit_vector(longint ang, output longint c, output longint s);
      longint z, x, y, t;
      bit flip;
      z = ang * 262144;
      x = StartGain;
      y = 0;
      flip = 1'b0;
      while (z > HalfTurn) z -= FullTurn;
      while (z < -HalfTurn) z += FullTurn;
      if (z > QuarterTurn) begin
        z -= HalfTurn;
        flip = 1'b1;
      end else if (z < -QuarterTurn) begin
        z += HalfTurn;
        flip = 1'b1;
      end
      for (int i = 0; i < CordicSteps && i < 24; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= atan_tab[i];
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += atan_tab[i];
        end
        x = t;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function logic signed [PosW-1:0] to_pos(longint q);
      longint r;
      r = (q + RoundHalf) >>> 30;
      return r[PosW-1:0];
    endfunction

    function pose_t predict_pose(logic [15:0] lift_in, logic [15:0] arm_in,
                                 logic [15:0] wrist_in);
      int lift, af, wf, hp;
      longint ca, sa, ch, sh, wx, wz;
      pose_t r;
      lift = limit_to(int'($signed(lift_in)), lift_min, lift_max);
      af   = limit_to(int'($signed(arm_in)), arm_min, arm_max);
      wf   = limit_to(int'($signed(wrist_in)), wrist_min, wrist_max);
      hp   = limit_to(-af - wf, -32768, 32767);
      unit_vector(-af, ca, sa);
      unit_vector(hp, ch, sh);
      wx = ShoulderX * Q30One + ca * UpperX + sa * UpperZ;
      wz = (LiftBaseZ + lift) * Q30One - sa * UpperX + ca * UpperZ;
      r.palm_x     = to_pos(wx + ch * PalmX + sh * PalmZ);
      r.palm_z     = to_pos(wz - sh * PalmX + ch * PalmZ);
      r.camera_x   = to_pos(wx + ch * CamX + sh * CamZ);
      r.camera_z   = to_pos(wz - sh * CamX + ch * CamZ);
      r.hand_pitch = hp[15:0];
      return r;
    endfunction

    function void note_pose(logic [15:0] lift_in, logic [15:0] arm_in, logic [15:0] wrist_in);
      pending_poses.push_back(predict_pose(lift_in, arm_in, wrist_in));
    endfunction

    function int pending();
      return pending_poses.size();
    endfunction

    function void complain(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void compare_field(string name, logic signed [PosW-1:0] want,
                                logic signed [PosW-1:0] got);
      if (want !== got) complain($sformatf("%s expected %0d got %0d", name, want, got));
    endfunction

    function void check_pose(pose_t got);
      pose_t want;
      if (pending_poses.size() == 0) begin
        complain("result with no pose outstanding");
        return;
      end
      want = pending_poses.pop_front();
      compare_field("palm_x", want.palm_x, got.palm_x);
      compare_field("palm_z", want.palm_z, got.palm_z);
      compare_field("camera_x", want.camera_x, got.camera_x);
      compare_field("camera_z", want.camera_z, got.camera_z);
      compare_field("hand_pitch", PosW'(want.hand_pitch), PosW'(got.hand_pitch));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall;
  logic signed [15:0] lift_height, arm_angle, wrist_angle;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [PosW-1:0] palm_x, palm_z, camera_x, camera_z;
  logic signed [15:0] hand_pitch;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [15:0] cfg_data;

  pose_scoreboard sb;
  int cycles = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int hold_req = 0, hold_ack = 0, hold_left = 0;
  int rx_left = 0;
  stall_pattern_e rx_mode = RxFree;

  arm_forward_kinematics dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .lift_height_i (lift_height),
    .arm_angle_i   (arm_angle),
    .wrist_angle_i (wrist_angle),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .palm_x_o      (palm_x),
    .palm_z_o      (palm_z),
    .camera_x_o    (camera_x),
    .camera_z_o    (camera_z),
    .hand_pitch_o  (hand_pitch),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin : result_monitor
    pose_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{palm_x, palm_z, camera_x, camera_z, hand_pitch};
      sb.check_pose(seen);
    end
  end

  // receiver: stretches of stall patterns, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = stall_pattern_e'($urandom_range(3));
        rx_left = $urandom_range(60, 1);
      end
      rx_left--;
      case (rx_mode)
        RxFree:  out_stall <= 1'b0;
        RxLight: out_stall <= ($urandom_range(3) == 0);
        RxHeavy: out_stall <= ($urandom_range(3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  function automatic int rand_s16();
    logic [15:0] r;
    r = 16'($urandom);
    return int'($signed(r));
  endfunction

  // full-range values, values near or at the limits, and some extremes
  function automatic logic [15:0] pick_field(int lo, int hi);
    int lo2, hi2, val;
    lo2 = (lo < hi) ? lo : hi;
    hi2 = lo + hi - lo2;
    lo2 = (lo2 - 64 < -32768) ? -32768 : lo2 - 64;
    hi2 = (hi2 + 64 > 32767) ? 32767 : hi2 + 64;
    case ($urandom_range(9))
      0, 1, 2, 3: val = rand_s16();
      4, 5, 6:    val = lo2 + int'($urandom_range(hi2 - lo2));
      7:          val = lo;
      8:          val = hi;
      default: begin
        case ($urandom_range(3))
          0:       val = -32768;
          1:       val = 32767;
          2:       val = 0;
          default: val = -1;
        endcase
      end
    endcase
    return 16'(val);
  endfunction

  // called and returns at a falling edge
  task automatic send_pose(input int lift, input int af, input int wf);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : (($urandom_range(4) == 0) ? $urandom_range(30) : $urandom_range(3));
      burst_left = $urandom_range(40, 1);
      repeat (gap) begin
        in_valid    = 1'b0;
        lift_height = 16'($urandom);
        arm_angle   = 16'($urandom);
        wrist_angle = 16'($urandom);
        @(negedge clk);
      end
    end
    in_valid    = 1'b1;
    lift_height = 16'(lift);
    arm_angle   = 16'(af);
    wrist_angle = 16'(wf);
    do @(posedge clk); while (in_stall);
    sb.note_pose(lift_height, arm_angle, wrist_angle);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    // pipeline depth plus margin
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    sb.set_limit(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_limits(input int lmin, input int lmax, input int amin,
                              input int amax, input int wmin, input int wmax);
    write_reg(RegLiftMin, 16'(lmin));
    write_reg(RegLiftMax, 16'(lmax));
    write_reg(RegArmMin, 16'(amin));
    write_reg(RegArmMax, 16'(amax));
    write_reg(RegWristMin, 16'(wmin));
    write_reg(RegWristMax, 16'(wmax));
  endtask

  task automatic apply_limits(input limit_mode_e mode);
    int v[6];
    int a, b;
    for (int k = 0; k < 6; k += 2) begin
      a = rand_s16();
      b = rand_s16();
      case (mode)
        LimDefault: ;
        LimFull: begin
          a = -32768;
          b = 32767;
        end
        LimRandom: begin
          if (a > b && $urandom_range(4) != 0) begin
            a = a + b;
            b = a - b;
            a = a - b;
          end
        end
        LimInverted: begin
          if (a < b) begin
            a = a + b;
            b = a - b;
            a = a - b;
          end
        end
        default: begin
          case ($urandom_range(3))
            0: begin a = -32768; b = -32768; end
            1: begin a = 32767;  b = 32767;  end
            2: begin a = 32767;  b = -32768; end
            default: b = a;
          endcase
        end
      endcase
      v[k]   = a;
      v[k+1] = b;
    end
    if (mode == LimDefault) write_limits(0, 11305, -10732, 0, -7864, 4997);
    else write_limits(v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  task automatic random_phase(input int n, input limit_mode_e mode, input bit squeeze);
    wait_drained();
    apply_limits(mode);
    if (squeeze) begin
      // receiver holds off while poses keep coming, so the pipeline backs up
      no_gaps = 1'b1;
      hold_req++;
    end
    repeat (n) begin
      send_pose(int'($signed(pick_field(sb.lift_min, sb.lift_max))),
                int'($signed(pick_field(sb.arm_min, sb.arm_max))),
                int'($signed(pick_field(sb.wrist_min, sb.wrist_max))));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    lift_height = '0;
    arm_angle   = '0;
    wrist_angle = '0;
    cfg_we      = 1'b0;
    cfg_idx     = RegLiftMin;
    cfg_data    = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // limits from reset
    send_pose(0, 0, 0);
    send_pose(11305, -10732, -7864);
    send_pose(-32768, -32768, -32768);
    send_pose(32767, 32767, 32767);
    send_pose(5000, -5000, 2000);
    send_pose(-1, -1, 4997);

    // open limits: hand pitch saturation and large angles
    wait_drained();
    apply_limits(LimFull);
    send_pose(32767, -32768, -32768);
    send_pose(-32768, 32767, 32767);
    send_pose(0, -32768, 0);
    send_pose(0, 32767, 0);
    send_pose(0, -12868, 0);
    send_pose(0, 12868, 0);
    send_pose(0, -6434, 0);
    send_pose(0, 6433, -12868);
    send_pose(1234, -20000, -30000);

    // inverted limits, then writes to unmapped indexes that must change nothing
    wait_drained();
    write_limits(1000, -1000, 500, -500, 300, -300);
    write_reg(RegSpare6, 16'h7fff);
    write_reg(RegSpare7, 16'h8000);
    send_pose(0, 0, 0);
    send_pose(32767, 32767, 32767);
    send_pose(-32768, -32768, -32768);

    random_phase(90, LimFull, 1'b1);
    random_phase(90, LimRandom, 1'b0);
    random_phase(90, LimDefault, 1'b0);
    random_phase(90, LimInverted, 1'b0);
    random_phase(90, LimPinned, 1'b0);
    random_phase(90, LimRandom, 1'b0);
    random_phase(90, LimRandom, 1'b0);

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- arm_forward_kinematics.f -----
design/afk_pkg.sv
design/afk_front.sv
design/afk_cell.sv
design/afk_back.sv
design/arm_forward_kinematics.sv
test/tb_arm_forward_kinematics.sv
